// ===== design/vtd_pkg.sv =====
// Types and constants shared by the vibration tamper detector.
// No dependencies.
package vtd_pkg;

  localparam int unsigned AddrW = 4;

  localparam logic [AddrW-1:0] ADDR_DEBOUNCE  = 4'h0;
  localparam logic [AddrW-1:0] ADDR_WINDOW    = 4'h4;
  localparam logic [AddrW-1:0] ADDR_THRESHOLD = 4'h8;

  localparam logic [15:0] DEBOUNCE_RESET  = 16'd100;
  localparam logic [31:0] WINDOW_RESET    = 32'd5000;
  localparam logic [7:0]  THRESHOLD_RESET = 8'd3;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [31:0] window_ms;
    logic [7:0]  threshold_count;
  } cfg_t;

  typedef struct packed {
    logic        sensor_level;
    logic [31:0] now_ms;
  } poll_t;

  typedef struct packed {
    logic       pulse_accepted;
    logic       alarm;
    logic [7:0] pulse_count;
  } result_t;

endpackage

// ===== design/vtd_cfg_regs.sv =====
// APB register bank for debounce, window and threshold settings.
// Depends on vtd_pkg.
module vtd_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [vtd_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output vtd_pkg::cfg_t              cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms     <= vtd_pkg::DEBOUNCE_RESET;
      cfg.window_ms       <= vtd_pkg::WINDOW_RESET;
      cfg.threshold_count <= vtd_pkg::THRESHOLD_RESET;
    end else if (wr) begin
      unique case (paddr)
        vtd_pkg::ADDR_DEBOUNCE:  cfg.debounce_ms     <= pwdata[15:0];
        vtd_pkg::ADDR_WINDOW:    cfg.window_ms       <= pwdata;
        vtd_pkg::ADDR_THRESHOLD: cfg.threshold_count <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      vtd_pkg::ADDR_DEBOUNCE:  prdata = {16'd0, cfg.debounce_ms};
      vtd_pkg::ADDR_WINDOW:    prdata = cfg.window_ms;
      vtd_pkg::ADDR_THRESHOLD: prdata = {24'd0, cfg.threshold_count};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

// ===== design/vtd_detect.sv =====
// Detector state and per-poll evaluation: window expiry, debounced edge, alarm.
// Depends on vtd_pkg.
module vtd_detect (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  vtd_pkg::cfg_t     cfg,
  input  vtd_pkg::poll_t    poll,
  output vtd_pkg::result_t  result
);

  logic        prev_level;
  logic [7:0]  count;
  logic [31:0] first_pulse_time;
  logic [31:0] last_pulse_time;

  logic [31:0] since_first;
  logic [31:0] since_last;
  logic [7:0]  count_kept;
  logic [7:0]  count_inc;
  logic        falling;
  logic        accept;
  logic        alarm;
  logic [7:0]  count_next;

  always_comb begin
    since_first = poll.now_ms - first_pulse_time;
    since_last  = poll.now_ms - last_pulse_time;
    count_kept  = (count != 8'd0 && since_first > cfg.window_ms) ? 8'd0 : count;
    falling     = !poll.sensor_level && prev_level;
    accept      = falling && (since_last > {16'd0, cfg.debounce_ms}
                              || poll.now_ms < last_pulse_time);
    count_inc   = (count_kept < vtd_pkg::COUNT_MAX) ? count_kept + 8'd1 : count_kept;
    alarm       = accept && (count_inc >= cfg.threshold_count);
    count_next  = alarm ? 8'd0 : (accept ? count_inc : count_kept);
  end

  assign result.pulse_accepted = accept;
  assign result.alarm          = alarm;
  assign result.pulse_count    = count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level       <= 1'b1;
      count            <= 8'd0;
      first_pulse_time <= 32'd0;
      last_pulse_time  <= 32'd0;
    end else if (step) begin
      prev_level <= poll.sensor_level;
      count      <= count_next;
      if (accept) begin
        last_pulse_time <= poll.now_ms;
        if (count_inc == 8'd1) first_pulse_time <= poll.now_ms;
      end
    end
  end

  a_alarm_needs_pulse: assert property (@(posedge clk) disable iff (rst)
    step && alarm |-> accept)
    else $error("alarm without accepted pulse");

  a_alarm_clears: assert property (@(posedge clk) disable iff (rst)
    step && alarm |=> count == 8'd0)
    else $error("count not cleared after alarm");

  a_last_time: assert property (@(posedge clk) disable iff (rst)
    step && accept |=> last_pulse_time == $past(poll.now_ms))
    else $error("pulse time not captured");

  a_edge_level: assert property (@(posedge clk) disable iff (rst)
    step |=> prev_level == $past(poll.sensor_level))
    else $error("level history lost");

endmodule

// ===== design/vibration_tamper_detector_core.sv =====
// Top level of the vibration tamper detector: stream ports, input and result
// registers. Depends on vtd_pkg, vtd_cfg_regs and vtd_detect.
//
//  port group   dir   contents
//  s_axis_*     in    poll item: sensor level, timestamp
//  m_axis_*     out   result item: pulse flag, alarm, count
//  apb          in    debounce, window, threshold registers
//
// One item per cycle sustained while results are taken; input register, then
// result register; evaluation is one pass of subtract/compare logic.
// Synchronous reset clears both stages and the detector state.
// A stalled result holds; an empty input register still takes one item while it waits.
module vibration_tamper_detector_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [39:0]                s_axis_tdata,  // [0] sensor_level, [32:1] now_ms
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [15:0]                m_axis_tdata,  // [0] pulse_accepted, [1] alarm,
                                                    // [9:2] pulse_count
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [vtd_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  vtd_pkg::cfg_t    cfg;
  vtd_pkg::poll_t   poll;
  vtd_pkg::result_t res_calc;
  vtd_pkg::result_t res;
  logic             in_valid;
  logic             out_load;

  assign out_load      = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid <= s_axis_tvalid;
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      poll.sensor_level <= s_axis_tdata[0];
      poll.now_ms       <= s_axis_tdata[32:1];
    end
    if (out_load) res <= res_calc;
  end

  assign m_axis_tdata = {6'd0, res.pulse_count, res.alarm, res.pulse_accepted};

  vtd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vtd_detect u_detect (
    .clk    (clk),
    .rst    (rst),
    .step   (out_load),
    .cfg    (cfg),
    .poll   (poll),
    .result (res_calc)
  );

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    in_valid && m_axis_tvalid && !m_axis_tready |=> in_valid)
    else $error("pending item dropped");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_axis_tready)
    else $error("input blocked while empty");

endmodule

// ===== sim/vibration_tamper_detector_core_tb.sv =====
// Testbench for vibration_tamper_detector_core: directed and random sensor polls,
// checked against an in-bench predictor of the debounce/window/threshold logic.
// Depends on vtd_pkg and the design files under design/.
module vibration_tamper_detector_core_tb;

  localparam logic [vtd_pkg::AddrW-1:0] ADDR_UNUSED = 4'hC;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // [0] sensor_level, [32:1] now_ms
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [15:0] m_axis_tdata;        // [0] pulse_accepted, [1] alarm, [9:2] pulse_count
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [vtd_pkg::AddrW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  vibration_tamper_detector_core uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // predictor state
  vtd_pkg::cfg_t cfg;
  logic        det_prev_level;
  logic [7:0]  det_count;
  logic [31:0] det_first_time;
  logic [31:0] det_last_time;

  vtd_pkg::result_t expected_results[$];
  int unsigned fail_count = 0;
  int unsigned polls_sent = 0;
  int unsigned results_seen = 0;
  int unsigned alarms_seen = 0;
  int unsigned pulses_seen = 0;
  int unsigned settings_used = 0;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;

  // random walk of the poll stream
  logic [31:0] walk_ms = '0;
  logic        walk_level = 1'b1;

  function automatic vtd_pkg::result_t detect_poll(vtd_pkg::poll_t p);
    vtd_pkg::result_t r;
    logic [31:0] since_first;
    logic [31:0] since_last;
    r = '0;
    since_first = p.now_ms - det_first_time;
    since_last = p.now_ms - det_last_time;
    if (det_count != 8'd0 && since_first > cfg.window_ms) det_count = 8'd0;
    if (!p.sensor_level && det_prev_level) begin
      if (since_last > {16'd0, cfg.debounce_ms} || p.now_ms < det_last_time) begin
        r.pulse_accepted = 1'b1;
        det_last_time = p.now_ms;
        if (det_count < vtd_pkg::COUNT_MAX) det_count = det_count + 8'd1;
        if (det_count == 8'd1) det_first_time = p.now_ms;
        if (det_count >= cfg.threshold_count) begin
          r.alarm = 1'b1;
          det_count = 8'd0;
        end
      end
    end
    det_prev_level = p.sensor_level;
    r.pulse_count = det_count;
    return r;
  endfunction

  task automatic note_failure(string what, vtd_pkg::result_t want, vtd_pkg::result_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s: expected acc=%0b alarm=%0b count=%0d, got acc=%0b alarm=%0b count=%0d",
               $time, what, want.pulse_accepted, want.alarm, want.pulse_count,
               got.pulse_accepted, got.alarm, got.pulse_count);
  endtask

  // Called just after a rising edge; returns just after the edge that took the item.
  task automatic send_poll(input vtd_pkg::poll_t p);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, p.now_ms, p.sensor_level};
    do @(posedge clk); while (!s_axis_tready);
    expected_results.push_back(detect_poll(p));
    polls_sent++;
  endtask

  task automatic send_at(input logic lvl, input logic [31:0] t);
    vtd_pkg::poll_t p;
    p.sensor_level = lvl;
    p.now_ms = t;
    send_poll(p);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [vtd_pkg::AddrW-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (addr)
      vtd_pkg::ADDR_DEBOUNCE:  cfg.debounce_ms = data[15:0];
      vtd_pkg::ADDR_WINDOW:    cfg.window_ms = data;
      vtd_pkg::ADDR_THRESHOLD: cfg.threshold_count = data[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [15:0] deb, input logic [31:0] win,
                                input logic [7:0] thr);
    wait_idle();
    write_reg(vtd_pkg::ADDR_DEBOUNCE, {16'd0, deb});
    write_reg(vtd_pkg::ADDR_WINDOW, win);
    write_reg(vtd_pkg::ADDR_THRESHOLD, {24'd0, thr});
    settings_used++;
  endtask

  // mostly rising timestamps with toggling level; some jumps back and random stamps
  task automatic send_walk(input int unsigned max_step, input bit noisy);
    int unsigned r;
    r = noisy ? $urandom_range(0, 99) : 99;
    if (r < 4) walk_ms = $urandom();
    else if (r < 9) walk_ms = walk_ms - $urandom_range(1, max_step + 1);
    else walk_ms = walk_ms + (noisy ? $urandom_range(0, max_step) : 32'd1);
    if (!noisy || $urandom_range(0, 3) != 0) walk_level = ~walk_level;
    send_at(walk_level, walk_ms);
  endtask

  task automatic test_reset_values();
    send_at(1'b1, 32'd0);
    send_at(1'b0, 32'd0);
    send_at(1'b1, 32'd50);
    send_at(1'b0, 32'd101);
    send_at(1'b1, 32'd150);
    send_at(1'b0, 32'd201);
    send_at(1'b0, 32'd202);
    send_at(1'b1, 32'd210);
    send_at(1'b0, 32'd302);
    send_at(1'b1, 32'd400);
    send_at(1'b0, 32'd350);          // timestamp went backwards
    send_at(1'b1, 32'hFFFF_FFF0);
    send_at(1'b0, 32'hFFFF_FFF0);
    send_at(1'b1, 32'h0000_0010);
    send_at(1'b0, 32'h0000_0020);    // wrapped, inside debounce
    send_at(1'b1, 32'd6000);
    send_at(1'b0, 32'd6000);         // window expired across the wrap
  endtask

  task automatic test_config_extremes();
    apply_settings(16'd0, 32'd0, 8'd1);
    send_at(1'b1, 32'd7000);
    send_at(1'b0, 32'd7001);
    send_at(1'b1, 32'd7001);
    send_at(1'b0, 32'd7001);
    // zero threshold, and a write to an unused address that must be ignored
    apply_settings(16'd0, 32'd0, 8'd0);
    write_reg(ADDR_UNUSED, $urandom());
    send_at(1'b1, 32'd8000);
    send_at(1'b0, 32'd8005);
    apply_settings(16'hFFFF, 32'hFFFF_FFFF, 8'd255);
    send_at(1'b1, 32'd9000);
    send_at(1'b0, 32'd9000 + 32'd65535);
    send_at(1'b1, 32'd9000 + 32'd65535);
    send_at(1'b0, 32'd9000 + 32'd65536);
    walk_ms = 32'd9000 + 32'd65536;
    walk_level = 1'b0;
  endtask

  task automatic test_random_settings();
    logic [15:0] deb;
    logic [31:0] win;
    logic [7:0]  thr;
    int unsigned max_step;
    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 3))
        0: deb = 16'd0;
        1: deb = 16'($urandom_range(1, 50));
        2: deb = 16'($urandom());
        default: deb = 16'hFFFF;
      endcase
      case ($urandom_range(0, 3))
        0: win = 32'd0;
        1: win = $urandom_range(0, 2000);
        2: win = $urandom();
        default: win = 32'hFFFF_FFFF;
      endcase
      case ($urandom_range(0, 3))
        0: thr = 8'd1;
        1: thr = 8'($urandom_range(2, 6));
        2: thr = 8'($urandom_range(1, 255));
        default: thr = 8'd255;
      endcase
      apply_settings(deb, win, thr);
      max_step = deb + deb / 2 + 3;
      for (int i = 0; i < 130; i++) begin
        if (i % 40 == 0) begin
          tx_idle = ($urandom_range(0, 3) != 0);
          rx_idle = ($urandom_range(0, 3) != 0);
        end
        send_walk(max_step, 1'b1);
      end
    end
  endtask

  task automatic test_full_threshold();
    apply_settings(16'd0, 32'hFFFF_FFFF, 8'd255);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    for (int i = 0; i < 520; i++) begin
      if (i == 260) begin
        tx_idle = 1'b1;
        rx_idle = 1'b1;
      end
      send_walk(1, 1'b0);
    end
  endtask

  initial begin : result_monitor
    vtd_pkg::result_t got;
    vtd_pkg::result_t want;
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        got.pulse_accepted = m_axis_tdata[0];
        got.alarm = m_axis_tdata[1];
        got.pulse_count = m_axis_tdata[9:2];
        results_seen++;
        if (got.alarm) alarms_seen++;
        if (got.pulse_accepted) pulses_seen++;
        if (expected_results.size() == 0) begin
          note_failure("unexpected result", '0, got);
        end else begin
          want = expected_results.pop_front();
          if (got.pulse_accepted !== want.pulse_accepted || got.alarm !== want.alarm ||
              got.pulse_count !== want.pulse_count)
            note_failure("result mismatch", want, got);
        end
        stall = rx_idle ? $urandom_range(0, 6) : 0;
        m_axis_tready <= (stall == 0);
      end else if (stall != 0) begin
        stall--;
        if (stall == 0) m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : run_limit
    #5000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    cfg.debounce_ms = vtd_pkg::DEBOUNCE_RESET;
    cfg.window_ms = vtd_pkg::WINDOW_RESET;
    cfg.threshold_count = vtd_pkg::THRESHOLD_RESET;
    det_prev_level = 1'b1;
    det_count = 8'd0;
    det_first_time = '0;
    det_last_time = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_config_extremes();
    test_random_settings();
    test_full_threshold();
    wait_idle();
    repeat (10) @(posedge clk);
    while (expected_results.size() != 0) begin
      note_failure("missing result", expected_results.pop_front(), '0);
    end
    $display("Sent %0d polls over %0d register settings; %0d results back, %0d pulses counted,",
             polls_sent, settings_used + 1, results_seen, pulses_seen);
    $display("%0d alarms raised, %0d failures", alarms_seen, fail_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
